>>> rtl/core/mlr_pkg.sv
// Package for the midpoint line rasterizer core.
// Holds coordinate widths, queue depths, opcodes and the payload and status structs.
// No dependencies.
package mlr_pkg;

  localparam int CB       = 12;
  localparam int DB       = CB + 1;
  localparam int EB       = CB + 2;
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                  opcode;
    logic signed [CB-1:0] start_x;
    logic signed [CB-1:0] start_y;
    logic signed [CB-1:0] finish_x;
    logic signed [CB-1:0] finish_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CB-1:0] pixel_x;
    logic signed [CB-1:0] pixel_y;
    logic                 valid_res;
    logic                 last;
  } out_item_t;

  // One classified command as it waits between front and back.
  typedef struct packed {
    op_t                  op;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] end_major;
    logic signed [EB-1:0] err;
    logic signed [EB-1:0] err_lo;
    logic signed [EB-1:0] err_hi;
    logic                 y_down;
    logic                 steep;
    logic                 fin;
  } cmd_t;

  typedef struct packed {
    logic [CQ_AW:0] count;
  } cq_stat_t;

  typedef struct packed {
    logic           issue;
    logic [OQ_AW:0] out_cnt;
  } back_stat_t;

endpackage

>>> rtl/core/midpoint_line_rasterizer_core.sv
// Midpoint line rasterizer: one result per item, one item per clock sustained
// while neither queue is full. The command queue is written at the accepting edge
// and the back end then steps the command into its result buffer for the pop.
// Throughput: one item per cycle unless a queue is full; the two-entry result
// buffer lets input go on while a result waits. Reset (synchronous, active low)
// empties both queues and leaves no line active.
module midpoint_line_rasterizer_core
  import mlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_data,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  cmd_t       front_cmd, head_cmd;
  logic       cq_empty, cq_pop, push_ok;
  cq_stat_t   cq_stat;
  back_stat_t back_stat;

  assign push_ok = in_push && !in_full;

  mlr_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  mlr_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push_ok),
    .wr_data (front_cmd),
    .rd_en   (cq_pop),
    .rd_data (head_cmd),
    .full    (in_full),
    .empty   (cq_empty),
    .stat    (cq_stat)
  );

  mlr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head_cmd),
    .cmd_empty (cq_empty),
    .cmd_pop   (cq_pop),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (out_data),
    .stat      (back_stat)
  );

`ifndef SYNTH
  // The back end never takes a command from an empty queue.
  a_issue_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.issue |-> cq_stat.count != '0)
    else $error("back end issued with no queued command");

  // An issued command with no result popped grows the result buffer by one.
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (back_stat.issue && !(out_pop && !out_empty)) |=>
      back_stat.out_cnt == $past(back_stat.out_cnt) + 1'b1)
    else $error("issued result not held in buffer");

  // An item accepted while the back end issues nothing is in the queue in the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !back_stat.issue) |=> cq_stat.count != '0)
    else $error("accepted item lost before the back end");
`endif

endmodule

>>> rtl/core/mlr_front.sv
// Front end: classifies each accepted item and works out the line set-up.
// Depends on mlr_pkg.
module mlr_front
  import mlr_pkg::*;
(
  input  in_item_t item,
  output cmd_t     cmd
);

  logic                 swap;
  logic signed [CB-1:0] xa, ya, xb, yb;
  logic signed [DB-1:0] dx, dy, dy_up, dy_dn;
  logic                 y_down, steep;

  always_comb begin
    swap   = item.start_x > item.finish_x;
    xa     = swap ? item.finish_x : item.start_x;
    ya     = swap ? item.finish_y : item.start_y;
    xb     = swap ? item.start_x  : item.finish_x;
    yb     = swap ? item.start_y  : item.finish_y;
    dx     = DB'(xb) - DB'(xa);
    dy_up  = DB'(yb) - DB'(ya);
    dy_dn  = DB'(ya) - DB'(yb);
    y_down = yb < ya;
    dy     = y_down ? dy_dn : dy_up;
    steep  = dy > dx;

    cmd.op        = item.opcode;
    cmd.x         = xa;
    cmd.y         = ya;
    cmd.y_down    = y_down;
    cmd.steep     = steep;
    if (steep) begin
      cmd.err       = EB'(dx) - EB'(dy >>> 1);
      cmd.err_lo    = EB'(dx);
      cmd.err_hi    = EB'(dx) - EB'(dy);
      cmd.end_major = yb;
      cmd.fin       = ya == yb;
    end else begin
      cmd.err       = EB'(dy) - EB'(dx >>> 1);
      cmd.err_lo    = EB'(dy);
      cmd.err_hi    = EB'(dy) - EB'(dx);
      cmd.end_major = xb;
      cmd.fin       = xa == xb;
    end
  end

endmodule

>>> rtl/core/mlr_cmdq.sv
// Short command queue between the front end and the stepping back end.
// Depends on mlr_pkg.
module mlr_cmdq
  import mlr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  cmd_t     wr_data,
  input  logic     rd_en,
  output cmd_t     rd_data,
  output logic     full,
  output logic     empty,
  output cq_stat_t stat
);

  cmd_t             mem [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_AW:0]   count_r, count_nxt;

  assign full       = count_r == (CQ_AW+1)'(CQ_DEPTH);
  assign empty      = count_r == '0;
  assign rd_data    = mem[rd_ptr_r];
  assign stat.count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (CQ_AW+1)'(wr_en) - (CQ_AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/mlr_back.sv
// Back end: holds the line state, buffers results and executes one command per
// cycle while a command waits and the result buffer has room. Depends on mlr_pkg.
module mlr_back
  import mlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  input  logic       res_pop,
  output logic       res_empty,
  output out_item_t  res,
  output back_stat_t stat
);

  logic signed [CB-1:0] cur_x_r, cur_x_nxt;
  logic signed [CB-1:0] cur_y_r, cur_y_nxt;
  logic signed [CB-1:0] end_r, end_nxt;
  logic signed [EB-1:0] err_r, err_nxt;
  logic signed [EB-1:0] lo_r, lo_nxt;
  logic signed [EB-1:0] hi_r, hi_nxt;
  logic                 y_down_r, y_down_nxt;
  logic                 steep_r, steep_nxt;
  logic                 busy_r, busy_nxt;

  out_item_t            obuf [OQ_DEPTH];
  logic [OQ_AW-1:0]     owr_r, ord_r;
  logic [OQ_AW:0]       ocnt_r, ocnt_nxt;

  logic                 issue, pop_ok, step_minor, fin;
  logic signed [CB-1:0] x_inc, y_inc;
  out_item_t            res_nxt;

  assign issue        = !cmd_empty && (ocnt_r != (OQ_AW+1)'(OQ_DEPTH));
  assign cmd_pop      = issue;
  assign pop_ok       = res_pop && !res_empty;
  assign res_empty    = ocnt_r == '0;
  assign res          = obuf[ord_r];
  assign stat.issue   = issue;
  assign stat.out_cnt = ocnt_r;

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    end_nxt    = end_r;
    err_nxt    = err_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    y_down_nxt = y_down_r;
    steep_nxt  = steep_r;
    busy_nxt   = busy_r;
    res_nxt    = '0;

    // The error term decides on its sign whether the minor axis moves.
    step_minor = !err_r[EB-1];
    x_inc      = cur_x_r + CB'(1);
    y_inc      = y_down_r ? cur_y_r - CB'(1) : cur_y_r + CB'(1);
    fin        = 1'b0;

    unique case (cmd.op)
      OP_START: begin
        cur_x_nxt  = cmd.x;
        cur_y_nxt  = cmd.y;
        end_nxt    = cmd.end_major;
        err_nxt    = cmd.err;
        lo_nxt     = cmd.err_lo;
        hi_nxt     = cmd.err_hi;
        y_down_nxt = cmd.y_down;
        steep_nxt  = cmd.steep;
        busy_nxt   = !cmd.fin;
        res_nxt    = '{pixel_x: cmd.x, pixel_y: cmd.y, valid_res: 1'b1, last: cmd.fin};
      end
      OP_STEP: begin
        if (busy_r) begin
          err_nxt = err_r + (step_minor ? hi_r : lo_r);
          if (steep_r) begin
            cur_y_nxt = y_inc;
            cur_x_nxt = step_minor ? x_inc : cur_x_r;
            fin       = y_inc == end_r;
          end else begin
            cur_x_nxt = x_inc;
            cur_y_nxt = step_minor ? y_inc : cur_y_r;
            fin       = x_inc == end_r;
          end
          busy_nxt = !fin;
          res_nxt  = '{pixel_x: cur_x_nxt, pixel_y: cur_y_nxt, valid_res: 1'b1, last: fin};
        end
      end
      default: begin
      end
    endcase

    ocnt_nxt = ocnt_r + (OQ_AW+1)'(issue) - (OQ_AW+1)'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (issue) begin
        busy_r <= busy_nxt;
        owr_r  <= owr_r + 1'b1;
      end
      if (pop_ok) begin
        ord_r <= ord_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      end_r       <= end_nxt;
      err_r       <= err_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      y_down_r    <= y_down_nxt;
      steep_r     <= steep_nxt;
      obuf[owr_r] <= res_nxt;
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for midpoint_line_rasterizer_core.
// Drives start and step transactions; a line tracer of its own predicts each pixel,
// but a directed row may type one in. Depends on mlr_pkg and the core module only.
module tb;
  import mlr_pkg::*;

  localparam int RAND_ITEMS = 900;
  localparam int HOLD_CYCLES = 200;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_data;
  logic      in_full;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;

  midpoint_line_rasterizer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Line tracer state, as it stands after every accepted transaction.
  int   px = 0;
  int   py = 0;
  int   stop_major = 0;
  int   span_x = 0;
  int   span_y = 0;
  int   decision = 0;
  logic falling = 1'b0;
  logic y_major = 1'b0;
  logic drawing = 1'b0;

  out_item_t pixel_q[$];
  int        taken_cnt = 0;
  int        popped_cnt = 0;
  int        errors = 0;

  // A directed row may carry a pixel typed in by hand; it travels with the item.
  logic      row_typed;
  out_item_t row_want;
  out_item_t exp_pixel;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } row_t;

  row_t directed_q[$];

  function automatic out_item_t trace_pixel(in_item_t it);
    out_item_t r;
    int        ax, ay, bx, by, t;
    logic      done;
    r = '0;
    if (it.opcode == OP_START) begin
      ax = it.start_x;
      ay = it.start_y;
      bx = it.finish_x;
      by = it.finish_y;
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      span_x  = bx - ax;
      falling = (by < ay);
      span_y  = falling ? ay - by : by - ay;
      y_major = (span_y > span_x);
      px = ax;
      py = ay;
      if (y_major) begin
        decision   = span_x - span_y / 2;
        stop_major = by;
        done       = (py == stop_major);
      end else begin
        decision   = span_y - span_x / 2;
        stop_major = bx;
        done       = (px == stop_major);
      end
    end else if (!drawing) begin
      return r;
    end else if (y_major) begin
      py = falling ? py - 1 : py + 1;
      if (decision < 0) begin
        decision += span_x;
      end else begin
        decision += span_x - span_y;
        px += 1;
      end
      done = (py == stop_major);
    end else begin
      px += 1;
      if (decision < 0) begin
        decision += span_y;
      end else begin
        decision += span_y - span_x;
        py = falling ? py - 1 : py + 1;
      end
      done = (px == stop_major);
    end
    drawing     = !done;
    r.pixel_x   = px[CB-1:0];
    r.pixel_y   = py[CB-1:0];
    r.valid_res = 1'b1;
    r.last      = done;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        popped_cnt++;
        if (pixel_q.size() == 0) begin
          $error("pixel transaction with nothing expected: x %0d y %0d",
                 out_data.pixel_x, out_data.pixel_y);
          errors++;
        end else begin
          exp_pixel = pixel_q.pop_front();
          check_field("pixel_x", exp_pixel.pixel_x, out_data.pixel_x);
          check_field("pixel_y", exp_pixel.pixel_y, out_data.pixel_y);
          check_field("valid_res", exp_pixel.valid_res, out_data.valid_res);
          check_field("last", exp_pixel.last, out_data.last);
        end
      end
      if (in_push && !in_full) begin
        taken_cnt++;
        exp_pixel = trace_pixel(in_data);
        if (row_typed) begin
          exp_pixel = row_want;
        end
        pixel_q.push_back(exp_pixel);
      end
    end
  end

  function automatic in_item_t make_item(op_t op, int sx, int sy, int fx, int fy);
    in_item_t it;
    it.opcode   = op;
    it.start_x  = sx[CB-1:0];
    it.start_y  = sy[CB-1:0];
    it.finish_x = fx[CB-1:0];
    it.finish_y = fy[CB-1:0];
    return it;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // Offset a coordinate, reflecting the offset when it would leave the range.
  function automatic int near(int c, int d);
    if (c + d > 2047 || c + d < -2048) begin
      return c - d;
    end
    return c + d;
  endfunction

  task automatic add_row(input op_t op, input int sx, input int sy, input int fx,
                         input int fy, input logic typed = 1'b0, input int wx = 0,
                         input int wy = 0, input logic wv = 1'b0, input logic wl = 1'b0);
    row_t r;
    r.item            = make_item(op, sx, sy, fx, fy);
    r.typed           = typed;
    r.want.pixel_x    = wx[CB-1:0];
    r.want.pixel_y    = wy[CB-1:0];
    r.want.valid_res  = wv;
    r.want.last       = wl;
    directed_q.push_back(r);
  endtask

  int send_calm = 0;

  task automatic push_item(input in_item_t item, input logic typed = 1'b0,
                           input out_item_t want = '0);
    int gap;
    int seen;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 39) == 0) begin
        send_calm = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data   = item;
    row_typed = typed;
    row_want  = want;
    in_push   = 1'b1;
    seen = taken_cnt;
    do @(negedge clk); while (taken_cnt == seen);
  endtask

  task automatic push_step();
    push_item(make_item(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord()));
  endtask

  // Sender: directed table first, then random lines.
  initial begin
    int   pick, reach, steps, span, ax, ay, bx, by, dx, dy, base;
    logic paused;
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    row_typed = 1'b0;
    row_want  = '0;
    paused    = 1'b0;

    add_row(OP_STEP, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);
    add_row(OP_START, -2048, -2048, -2048, -2048, 1'b1, -2048, -2048, 1'b1, 1'b1);
    add_row(OP_STEP, 2047, 2047, 2047, 2047, 1'b1, 0, 0, 1'b0, 1'b0);
    // Full-range diagonal given right to left, so the endpoints are swapped.
    add_row(OP_START, 2047, -2048, -2048, 2047, 1'b1, -2048, 2047, 1'b1, 1'b0);
    add_row(OP_STEP, 0, 0, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 0);
    // Steep falling line: it must run all the way down to y = -7.
    add_row(OP_START, 0, 0, 2, -7, 1'b1, 0, 0, 1'b1, 1'b0);
    repeat (7) add_row(OP_STEP, 0, 0, 0, 0);
    add_row(OP_STEP, -1, -1, -1, -1, 1'b1, 0, 0, 1'b0, 1'b0);
    add_row(OP_START, 3, 5, 3, 9, 1'b1, 3, 5, 1'b1, 1'b0);
    add_row(OP_STEP, 0, 0, 0, 0);
    // A new start abandons the vertical line after its first step.
    add_row(OP_START, 10, 0, 13, 1, 1'b1, 10, 0, 1'b1, 1'b0);
    repeat (3) add_row(OP_STEP, 0, 0, 0, 0);
    add_row(OP_START, 5, 5, 0, 5, 1'b1, 0, 5, 1'b1, 1'b0);
    add_row(OP_STEP, 0, 0, 0, 0);
    add_row(OP_START, 2047, 2047, 2047, 2047, 1'b1, 2047, 2047, 1'b1, 1'b1);
    add_row(OP_STEP, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_q[i]) begin
      push_item(directed_q[i].item, directed_q[i].typed, directed_q[i].want);
    end

    base = taken_cnt;
    while (taken_cnt - base < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_step();
      end else begin
        ax = rand_coord();
        ay = rand_coord();
        if (pick < 16) begin
          // Long line anywhere in the plane, abandoned after a few pixels.
          bx    = rand_coord();
          by    = rand_coord();
          steps = $urandom_range(0, 6);
        end else begin
          reach = (pick < 20) ? 0 : (pick < 24) ? 60 : 12;
          bx = near(ax, int'($urandom_range(0, 2 * reach)) - reach);
          by = near(ay, int'($urandom_range(0, 2 * reach)) - reach);
          dx = (bx > ax) ? bx - ax : ax - bx;
          dy = (by > ay) ? by - ay : ay - by;
          span  = (dx > dy) ? dx : dy;
          steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span)
                                              : span + $urandom_range(0, 2);
        end
        push_item(make_item(OP_START, ax, ay, bx, by));
        repeat (steps) push_step();
      end
      // Let the pipeline drain completely once mid-run.
      if (!paused && taken_cnt - base >= 500) begin
        paused  = 1'b1;
        in_push = 1'b0;
        while (pixel_q.size() != 0) @(negedge clk);
      end
    end
    in_push = 1'b0;

    while (pixel_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random pop gaps, with one long hold-off so the input side backs up.
  initial begin
    int   gap;
    int   seen;
    int   take_calm;
    logic held;
    out_pop   = 1'b0;
    take_calm = 0;
    held      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (take_calm > 0) begin
        take_calm--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 39) == 0) begin
          take_calm = $urandom_range(10, 40);
        end
      end
      if (!held && popped_cnt >= 300) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop = 1'b1;
      seen = popped_cnt;
      do @(negedge clk); while (popped_cnt == seen);
    end
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
